>>> sv/spmr_pkg.sv
// Package for the shuffled minimal-standard random generator.
// Holds the request/result types, the sequencer states and the shared constants and helpers.
// No dependencies.
package spmr_pkg;

    // Generator constants: x <- 16807 * x mod (2^31 - 1).
    localparam logic [14:0] MULT      = 15'd16807;
    localparam logic [30:0] MODULUS   = 31'h7FFF_FFFF;
    localparam logic [23:0] FRAC_CAP  = 24'd16777214;
    localparam int          WARMUP_EXTRA = 8;

    // Command codes carried in the request.
    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // One request: a draw, or a seed load followed by a draw.
    typedef struct packed {
        logic               command;
        logic signed [31:0] seed_value;
    } t_in;

    // One result.
    typedef struct packed {
        logic [30:0] random_value;
        logic [23:0] fraction;
        logic [30:0] new_state;
    } t_out;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_WARM_MUL,
        S_WARM_FOLD,
        S_DRAW_MUL,
        S_DRAW_FOLD,
        S_DIV,
        S_READ,
        S_UPDATE,
        S_FINISH
    } t_state;

    // Reduce a value in 1 .. 2^32-3 modulo 2^31 - 1; a zero residue becomes 1.
    function automatic logic [30:0] bring_into_range(input logic [31:0] v);
        logic [31:0] r;
        r = (v >= {1'b0, MODULUS}) ? (v - {1'b0, MODULUS}) : v;
        return (r == 32'd0) ? 31'd1 : r[30:0];
    endfunction

    // Q0.24 scaling: floor(val * 2^24 / (2^31 - 1)), capped.
    // With hi = val >> 7 and lo = (val mod 128) << 24, the quotient is hi plus
    // one when hi + lo reaches the modulus.
    function automatic logic [23:0] to_fraction(input logic [30:0] val);
        logic [31:0] t;
        logic [24:0] q;
        t = {8'd0, val[30:7]} + {1'b0, val[6:0], 24'd0};
        q = {1'b0, val[30:7]} + {24'd0, (t >= {1'b0, MODULUS})};
        return (q > {1'b0, FRAC_CAP}) ? FRAC_CAP : q[23:0];
    endfunction

endpackage

>>> sv/spmr_mulmod.sv
// Shared modular multiplier: registered product by 16807, then a Mersenne fold.
// The result is valid in the cycle after the operand is presented.
// Depends on spmr_pkg.
module spmr_mulmod (
    input  logic        i_clk,
    input  logic [30:0] i_x,
    output logic [30:0] o_y
);

    logic [45:0] r_prod;
    logic [31:0] fold_sum;

    // Product stage: 31 x 15 bits.
    always_ff @(posedge i_clk) begin
        r_prod <= {15'd0, i_x} * {31'd0, spmr_pkg::MULT};
    end

    // Fold stage: 2^31 is 1 modulo 2^31 - 1, so add the high part to the low part
    // and subtract the modulus once if needed.
    always_comb begin
        fold_sum = {1'b0, r_prod[30:0]} + {17'd0, r_prod[45:31]};
        if (fold_sum >= {1'b0, spmr_pkg::MODULUS}) begin
            fold_sum = fold_sum - {1'b0, spmr_pkg::MODULUS};
        end
        o_y = fold_sum[30:0];
    end

endmodule

>>> sv/shuffled_park_miller_rng.sv
// Top level of the shuffled minimal-standard random generator with its shuffle table.
// Depends on spmr_pkg and spmr_mulmod.
//
//   Channel   Direction   Handshake                   Payload
//   request   in          i_in_valid / o_in_ready     i_in  (spmr_pkg::t_in)
//   result    out         o_out_valid / i_out_ready   o_out (spmr_pkg::t_out)
//
// A plain draw runs from acceptance to the next acceptance through the multiply and fold
// states, the reciprocal slot division, the registered table read, the table update and
// the result hand-off.
// A reseed first runs warm-up steps through the same multiplier; the first request after
// reset always reseeds.
// Reset is synchronous; the shuffle table needs no clearing pass, it is filled before use.
// A result waits in the output register; a stalled output holds the next result in
// the final state and keeps o_in_ready low.
module shuffled_park_miller_rng #(
    parameter int TABLE_SIZE = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  spmr_pkg::t_in     i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output spmr_pkg::t_out    o_out
);

    localparam int QW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + spmr_pkg::WARMUP_EXTRA);
    localparam logic [31:0] SLOT_DIV =
        32'd1 + ({1'b0, spmr_pkg::MODULUS} - 32'd1) / 32'(TABLE_SIZE);
    // Reciprocal for the slot division: floor(n * RECIP / 2^RSH) equals
    // floor(n / SLOT_DIV) for every 31-bit n.
    localparam int          RSH = 31 + $clog2(SLOT_DIV);
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RSH) + 64'(SLOT_DIV) - 64'd1) / 64'(SLOT_DIV);
    localparam logic [31:0] RECIP = 32'(RECIP_FULL);

    spmr_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    spmr_pkg::t_out   r_out, n_out;
    logic [30:0]      r_lcg, n_lcg;
    logic [30:0]      r_last, n_last;
    logic [30:0]      r_x, n_x;
    logic [30:0]      r_val, n_val;
    logic [30:0]      r_rem, n_rem;
    logic [QW-1:0]    r_q, n_q;
    logic [CW-1:0]    r_cnt, n_cnt;

    logic [30:0]      r_table [TABLE_SIZE];
    logic [30:0]      r_rdata;
    logic             tbl_we;
    logic [QW-1:0]    tbl_waddr;
    logic [30:0]      tbl_wdata;

    logic [30:0]      fold_y;
    logic             seed_neg;
    logic             seed_zero;
    logic             reseed;
    logic [31:0]      start_val;
    logic [62:0]      slot_prod;

    // Shared multiply/fold unit, always fed from the working value.
    spmr_mulmod u_mulmod (
        .i_clk (i_clk),
        .i_x   (r_x),
        .o_y   (fold_y)
    );

    assign o_in_ready  = (r_state == spmr_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Slot product of the last output and the reciprocal.
    assign slot_prod = {32'd0, r_rem} * {31'd0, RECIP};

    // Request decode: choose between a reseed and a plain draw, and the starting value.
    // The seed only counts for a load; a plain draw starts from the generator state.
    always_comb begin
        seed_neg  = (i_in.command == spmr_pkg::CMD_LOAD) && i_in.seed_value[31];
        seed_zero = (i_in.seed_value == 32'sd0);
        reseed    = ((i_in.command == spmr_pkg::CMD_LOAD) && (seed_neg || seed_zero))
                    || (r_last == 31'd0);
        if (reseed) begin
            start_val = seed_neg ? (32'd0 - i_in.seed_value) : 32'd1;
        end else if (i_in.command == spmr_pkg::CMD_LOAD) begin
            start_val = i_in.seed_value;
        end else begin
            start_val = {1'b0, r_lcg};
        end
    end

    // Sequencer: next state, datapath updates and table write control.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        n_lcg       = r_lcg;
        n_last      = r_last;
        n_x         = r_x;
        n_val       = r_val;
        n_rem       = r_rem;
        n_q         = r_q;
        n_cnt       = r_cnt;
        tbl_we      = 1'b0;
        tbl_waddr   = r_q;
        tbl_wdata   = r_x;
        case (r_state)
            spmr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_x     = spmr_pkg::bring_into_range(start_val);
                    n_cnt   = CW'(TABLE_SIZE + spmr_pkg::WARMUP_EXTRA - 1);
                    n_state = reseed ? spmr_pkg::S_WARM_MUL : spmr_pkg::S_DRAW_MUL;
                end
            end
            spmr_pkg::S_WARM_MUL: begin
                n_state = spmr_pkg::S_WARM_FOLD;
            end
            // Warm-up step; the last TABLE_SIZE steps fill the table from the top down.
            spmr_pkg::S_WARM_FOLD: begin
                n_x = fold_y;
                if (r_cnt < CW'(TABLE_SIZE)) begin
                    tbl_we    = 1'b1;
                    tbl_waddr = r_cnt[QW-1:0];
                    tbl_wdata = fold_y;
                end
                if (r_cnt == '0) begin
                    n_last  = fold_y;
                    n_state = spmr_pkg::S_DRAW_MUL;
                end else begin
                    n_cnt   = r_cnt - CW'(1);
                    n_state = spmr_pkg::S_WARM_MUL;
                end
            end
            spmr_pkg::S_DRAW_MUL: begin
                n_state = spmr_pkg::S_DRAW_FOLD;
            end
            // Advance the state and hold the last output for the slot division.
            spmr_pkg::S_DRAW_FOLD: begin
                n_x     = fold_y;
                n_lcg   = fold_y;
                n_rem   = r_last;
                n_state = spmr_pkg::S_DIV;
            end
            // Slot of the last output by reciprocal multiplication.
            spmr_pkg::S_DIV: begin
                n_q     = QW'(slot_prod >> RSH);
                n_state = spmr_pkg::S_READ;
            end
            spmr_pkg::S_READ: begin
                n_state = spmr_pkg::S_UPDATE;
            end
            // Take the slot's value and refill the slot with the new state.
            spmr_pkg::S_UPDATE: begin
                n_val     = r_rdata;
                n_last    = r_rdata;
                tbl_we    = 1'b1;
                tbl_waddr = r_q;
                tbl_wdata = r_x;
                n_state   = spmr_pkg::S_FINISH;
            end
            spmr_pkg::S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.random_value = r_val;
                    n_out.fraction     = spmr_pkg::to_fraction(r_val);
                    n_out.new_state    = r_x;
                    n_out_valid        = 1'b1;
                    n_state            = spmr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spmr_pkg::S_IDLE;
            end
        endcase
    end

    // Control and generator state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spmr_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_lcg       <= 31'd1;
            r_last      <= 31'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_lcg       <= n_lcg;
            r_last      <= n_last;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_x   <= n_x;
        r_val <= n_val;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_cnt <= n_cnt;
    end

    // Shuffle table: one write port, one registered read port at the slot.
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_table[tbl_waddr] <= tbl_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_table[r_q];
    end

`ifndef SYNTHESIS
    // The slot found by the division always lies inside the table.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spmr_pkg::S_READ) |-> (32'(r_q) < 32'(TABLE_SIZE)))
        else $error("slot index beyond table");

    // An accepted request starts either the warm-up or a plain draw.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=>
        (r_state == spmr_pkg::S_WARM_MUL || r_state == spmr_pkg::S_DRAW_MUL))
        else $error("bad state after request");

    // The generator state never sticks at zero or reaches the modulus.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lcg != 31'd0) && (r_lcg != spmr_pkg::MODULUS))
        else $error("generator state out of range");

    // A draw never starts with an empty table.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spmr_pkg::S_DRAW_MUL) |-> (r_last != 31'd0))
        else $error("draw with empty table");

    // A delivered result agrees with the stored state and last output.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spmr_pkg::S_FINISH && (!r_out_valid || i_out_ready)) |=>
        (o_out.new_state == r_lcg && o_out.random_value == r_last))
        else $error("result disagrees with generator state");
`endif

endmodule

>>> verif/testbench.sv
// Self-checking testbench for shuffled_park_miller_rng: random draw and seed-load requests,
// with every result checked against a cycle-free model of the generator and its shuffle table.
// Depends on spmr_pkg and the shuffled_park_miller_rng RTL.
module testbench;

    localparam int          TABLE_SIZE   = 32;
    localparam int          WARMUP_STEPS = TABLE_SIZE + spmr_pkg::WARMUP_EXTRA;
    localparam logic [31:0] SLOT_DIV     = 32'd1 + (32'h7FFF_FFFE / TABLE_SIZE);
    localparam int          RANDOM_REQS  = 1950;
    localparam int          DRAIN_CYCLES = 150;
    localparam int          CYCLE_LIMIT  = 2_000_000;
    localparam int          HOLD_AFTER   = 400;
    localparam int          HOLD_CYCLES  = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic o_in_ready;
    spmr_pkg::t_in  in_req = '0;
    logic o_out_valid;
    logic out_ready = 1'b0;
    spmr_pkg::t_out o_out;

    // Model copy of the generator state.
    logic [30:0] gen_state;
    logic [30:0] last_drawn;
    logic [30:0] shuffle_copy [TABLE_SIZE];

    spmr_pkg::t_in  pending_reqs [$];
    spmr_pkg::t_out expected_draws [$];
    int   reqs_total = 0;
    int   reqs_accepted = 0;
    int   results_seen = 0;
    int   error_count = 0;
    int   send_gap = 0;
    int   recv_stall = 0;
    int   hold_cycles = 0;
    logic hold_done = 1'b0;
    int   cycle_count = 0;

    shuffled_park_miller_rng #(
        .TABLE_SIZE(TABLE_SIZE)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (in_req),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out      (o_out)
    );

    // Clock generation.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // One multiplicative step: x * 16807 mod (2^31 - 1).
    function automatic logic [30:0] lcg_advance(input logic [30:0] v);
        logic [63:0] prod;
        prod = 64'(v) * 64'(spmr_pkg::MULT);
        return 31'(prod % 64'(spmr_pkg::MODULUS));
    endfunction

    // Reduce a seed modulo 2^31 - 1; a zero residue would freeze the generator, so it becomes 1.
    function automatic logic [30:0] fold_seed(input logic [63:0] v);
        logic [63:0] r;
        r = v % 64'(spmr_pkg::MODULUS);
        return (r == 64'd0) ? 31'd1 : 31'(r);
    endfunction

    // Advance the model by one request and return the result it must produce.
    function automatic spmr_pkg::t_out predict_draw(input spmr_pkg::t_in req);
        longint         seed_work;
        logic [30:0]    x;
        logic [31:0]    slot;
        logic [30:0]    val;
        logic [63:0]    scaled;
        spmr_pkg::t_out res;
        int             j;
        if (req.command == spmr_pkg::CMD_LOAD) begin
            seed_work = longint'(req.seed_value);
        end else begin
            seed_work = longint'({33'd0, gen_state});
        end
        // A non-positive seed or an empty table forces warm-up and a table refill.
        if (seed_work <= 0 || last_drawn == 31'd0) begin
            x = (seed_work >= 0) ? 31'd1 : fold_seed(64'(-seed_work));
            for (j = WARMUP_STEPS - 1; j >= 0; j--) begin
                x = lcg_advance(x);
                if (j < TABLE_SIZE) begin
                    shuffle_copy[j] = x;
                end
            end
            last_drawn = shuffle_copy[0];
        end else begin
            x = fold_seed(64'(seed_work));
        end
        x = lcg_advance(x);
        gen_state = x;
        // The previous output picks the slot; the new state takes its place.
        slot = {1'b0, last_drawn} / SLOT_DIV;
        if (slot >= TABLE_SIZE) begin
            slot = TABLE_SIZE - 1;
        end
        val = shuffle_copy[slot];
        last_drawn = val;
        shuffle_copy[slot] = x;
        scaled = {33'd0, val} << 24;
        scaled = scaled / 64'(spmr_pkg::MODULUS);
        if (scaled > 64'(spmr_pkg::FRAC_CAP)) begin
            scaled = 64'(spmr_pkg::FRAC_CAP);
        end
        res.random_value = val;
        res.fraction = scaled[23:0];
        res.new_state = x;
        return res;
    endfunction

    // Idle length for either side: mostly none, some short, a few long, and calm stretches.
    function automatic int pick_idle(input int progress);
        int r;
        if ((progress / 128) % 4 == 1) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Seeds for load requests, weighted toward the normal positive range.
    function automatic logic [31:0] pick_seed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return 32'($urandom_range(1, 32'h7FFF_FFFE));
        end
        if (r < 88) begin
            return -32'($urandom_range(1, 32'h7FFF_FFFE));
        end
        if (r < 93) begin
            return 32'd0;
        end
        return $urandom();
    endfunction

    task automatic add_req(input logic cmd, input logic [31:0] seed);
        spmr_pkg::t_in r;
        r.command = cmd;
        r.seed_value = seed;
        pending_reqs.push_back(r);
        reqs_total++;
    endtask

    // Compare one result with the oldest expectation.
    task automatic check_result(input spmr_pkg::t_out got);
        spmr_pkg::t_out want;
        if (expected_draws.size() == 0) begin
            $error("unexpected result: random_value %0d", got.random_value);
            error_count++;
        end else begin
            want = expected_draws.pop_front();
            if (got.random_value !== want.random_value) begin
                $error("random_value: expected %0d, got %0d", want.random_value,
                       got.random_value);
                error_count++;
            end
            if (got.fraction !== want.fraction) begin
                $error("fraction: expected %0d, got %0d", want.fraction, got.fraction);
                error_count++;
            end
            if (got.new_state !== want.new_state) begin
                $error("new_state: expected %0d, got %0d", want.new_state, got.new_state);
                error_count++;
            end
        end
    endtask

    // Request driver: predicts on acceptance, then offers the next request after a gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_draws.push_back(predict_draw(in_req));
                reqs_accepted++;
            end
            if (!in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    in_req <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    send_gap = pick_idle(reqs_accepted);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                check_result(o_out);
                results_seen++;
            end
            if (recv_stall > 0) begin
                recv_stall--;
            end else begin
                recv_stall = pick_idle(results_seen + 64);
            end
            out_ready <= (recv_stall == 0) && (hold_cycles == 0);
        end
    end

    // One long receiver hold-off so that the block fills and blocks new requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cycles <= 0;
            hold_done <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_cycles <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Model reset, stimulus, and end of run.
    initial begin
        int i;
        int r;
        gen_state = 31'd1;
        last_drawn = 31'd0;
        for (i = 0; i < TABLE_SIZE; i++) begin
            shuffle_copy[i] = 31'd0;
        end

        // Directed: a positive load right after reset still reseeds from 1.
        add_req(spmr_pkg::CMD_LOAD, 32'd12345);
        add_req(spmr_pkg::CMD_DRAW, 32'd0);
        add_req(spmr_pkg::CMD_DRAW, 32'hFFFF_FFFF);
        // Zero and negative seeds force a refill.
        add_req(spmr_pkg::CMD_LOAD, 32'd0);
        add_req(spmr_pkg::CMD_DRAW, 32'd0);
        add_req(spmr_pkg::CMD_LOAD, 32'hFFFF_FFFF);
        // The most negative seed negates to 2^31, which folds to 1.
        add_req(spmr_pkg::CMD_LOAD, 32'h8000_0000);
        add_req(spmr_pkg::CMD_DRAW, 32'h8000_0000);
        // Seeds at and near the modulus, positive and negative, fold into range.
        add_req(spmr_pkg::CMD_LOAD, 32'h7FFF_FFFF);
        add_req(spmr_pkg::CMD_LOAD, 32'd2147483646);
        add_req(spmr_pkg::CMD_LOAD, -32'd2147483646);
        add_req(spmr_pkg::CMD_LOAD, 32'h8000_0001);
        add_req(spmr_pkg::CMD_LOAD, 32'd1);
        add_req(spmr_pkg::CMD_DRAW, 32'h5555_5555);
        add_req(spmr_pkg::CMD_DRAW, 32'hAAAA_AAAA);
        add_req(spmr_pkg::CMD_DRAW, 32'h7FFF_FFFF);
        add_req(spmr_pkg::CMD_LOAD, 32'h5555_5555);
        add_req(spmr_pkg::CMD_LOAD, 32'hAAAA_AAAA);
        add_req(spmr_pkg::CMD_DRAW, 32'd0);
        add_req(spmr_pkg::CMD_DRAW, 32'd0);

        // Random: mostly draws, with loads of varied seeds mixed in.
        for (i = 0; i < RANDOM_REQS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 88) begin
                add_req(spmr_pkg::CMD_DRAW, $urandom());
            end else begin
                add_req(spmr_pkg::CMD_LOAD, pick_seed());
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (reqs_accepted < reqs_total || expected_draws.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_draws.size() > 0) begin
            $error("%0d expected results never arrived", expected_draws.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
